[design/pkvt_pkg.sv]
// particle kill-volume test: shared package
// holds the kill shape codes, configuration register indexes and fixed widths
// no dependencies
`default_nettype none

package pkvt_pkg;

  // kill volume selection
  typedef enum logic [1:0] {
    SHAPE_NONE   = 2'd0,
    SHAPE_BOX    = 2'd1,
    SHAPE_PLANE  = 2'd2,
    SHAPE_SPHERE = 2'd3
  } kill_shape_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL_SHAPE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_FULL_XFM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL_INSIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_CENTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_VECTOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_SCALAR  = 3'd5;

  // local space keeps 24 fractional bits: Q.8 values shift up by 16
  localparam int unsigned LOCAL_SHIFT = 16;
  // wrap width of intermediate sums and products other than the exact squares
  localparam int unsigned WIDE_W = 64;
  // width of exact squared distances
  localparam int unsigned SQ_W = 128;

endpackage

`default_nettype wire

[design/pkvt_xform.sv]
// particle kill-volume test: global to effect-local position transform
// two register stages: matrix products, then sum and path select
// depends on pkvt_pkg
`default_nettype none

module pkvt_xform #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic                                 use_full_i,
  input  logic signed [COORD_WIDTH-1:0]        pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]        pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]        pos_z_i,
  input  logic        [3*COORD_WIDTH-1:0]      inv_row0_i,
  input  logic        [3*COORD_WIDTH-1:0]      inv_row1_i,
  input  logic        [3*COORD_WIDTH-1:0]      inv_row2_i,
  input  logic        [3*COORD_WIDTH-1:0]      inv_row3_i,
  input  logic        [3*COORD_WIDTH-1:0]      global_translation_i,
  output logic                                 valid_o,
  output logic        [2:0][pkvt_pkg::WIDE_W-1:0] loc_o
);
  import pkvt_pkg::*;

  localparam int unsigned W         = COORD_WIDTH;
  localparam int unsigned PW        = 3 * W;
  // lanes that start beyond the 64-bit word read as zero
  localparam int unsigned LANE_BITS = (PW > WIDE_W) ? WIDE_W : PW;

  logic [PW-1:0] row0_ext, row1_ext, row2_ext, row3_ext, gtr_ext;
  logic signed [W-1:0] pos [3];
  logic signed [W-1:0] coef [3][3];

  logic signed [2*W-1:0] prod_d [3][3];
  logic signed [2*W-1:0] prod_q [3][3];
  logic signed [W-1:0]   trans_d [3];
  logic signed [W-1:0]   trans_q [3];
  logic signed [W:0]     diff_d [3];
  logic signed [W:0]     diff_q [3];
  logic                  va_q;

  logic [2:0][WIDE_W-1:0] loc_d;
  logic [2:0][WIDE_W-1:0] loc_q;
  logic                   vb_q;

  // lane unpacking
  assign row0_ext = PW'(inv_row0_i[LANE_BITS-1:0]);
  assign row1_ext = PW'(inv_row1_i[LANE_BITS-1:0]);
  assign row2_ext = PW'(inv_row2_i[LANE_BITS-1:0]);
  assign row3_ext = PW'(inv_row3_i[LANE_BITS-1:0]);
  assign gtr_ext  = PW'(global_translation_i[LANE_BITS-1:0]);

  // stage a: nine coefficient products and the translation-only difference
  always_comb begin
    pos[0] = pos_x_i;
    pos[1] = pos_y_i;
    pos[2] = pos_z_i;
    for (int j = 0; j < 3; j++) begin
      coef[0][j] = row0_ext[j*W +: W];
      coef[1][j] = row1_ext[j*W +: W];
      coef[2][j] = row2_ext[j*W +: W];
      trans_d[j] = row3_ext[j*W +: W];
      diff_d[j]  = (W+1)'(pos[j]) - (W+1)'($signed(gtr_ext[j*W +: W]));
    end
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[r][j] = pos[r] * coef[r][j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      trans_q <= trans_d;
      diff_q  <= diff_d;
      loc_q   <= loc_d;
    end
  end

  // stage b: sum of products plus translation, or shifted difference
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (use_full_i) begin
        loc_d[j] = WIDE_W'(prod_q[0][j]) + WIDE_W'(prod_q[1][j]) + WIDE_W'(prod_q[2][j])
                 + (WIDE_W'(trans_q[j]) << LOCAL_SHIFT);
      end else begin
        loc_d[j] = WIDE_W'(diff_q[j]) << LOCAL_SHIFT;
      end
    end
  end

  assign valid_o = vb_q;
  assign loc_o   = loc_q;

endmodule

`default_nettype wire

[design/particle_kill_volume_test_core.sv]
// particle kill-volume test: top level with configuration and shape tests
// depends on pkvt_pkg and pkvt_xform
//
// usage:
//   configuration is written through cfg_valid_i/cfg_ready_o with a register
//   index and data; cfg_ready_o is always high. write only while the block
//   holds no item in flight.
//   each particle enters on in_valid_i/in_ready_o with its position, the
//   inverse effect matrix and the effect translation. exactly one item leaves
//   on out_valid_o/out_ready_i carrying remove_particle_o.
// throughput:
//   one item per cycle while the output item is taken.
//   the arithmetic pipeline has eight stages: two stages of
//   transform, then difference, magnitude, split products, partial sums,
//   total and compare.
// reset:
//   pipeline valid bits clear; kill shape none, full transform on, kill
//   outside, all shape values zero.
// stall:
//   when the output item is not taken, the whole pipeline holds and
//   in_ready_o drops in the same cycle; nothing is lost or repeated.
`default_nettype none

module particle_kill_volume_test_core #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pkvt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [3*COORD_WIDTH-1:0]               cfg_data_i,
  // input items
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]          pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]          pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]          pos_z_i,
  input  logic        [3*COORD_WIDTH-1:0]        inv_row0_i,
  input  logic        [3*COORD_WIDTH-1:0]        inv_row1_i,
  input  logic        [3*COORD_WIDTH-1:0]        inv_row2_i,
  input  logic        [3*COORD_WIDTH-1:0]        inv_row3_i,
  input  logic        [3*COORD_WIDTH-1:0]        global_translation_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   remove_particle_o
);
  import pkvt_pkg::*;

  localparam int unsigned W         = COORD_WIDTH;
  localparam int unsigned PW        = 3 * W;
  localparam int unsigned LANE_BITS = (PW > WIDE_W) ? WIDE_W : PW;

  // configuration registers
  kill_shape_e         kill_shape_q;
  logic                use_full_q;
  logic                kill_inside_q;
  logic [PW-1:0]       shape_center_q;
  logic [PW-1:0]       shape_vector_q;
  logic signed [W-1:0] shape_scalar_q;

  logic                   en;
  logic                   xf_valid;
  logic [2:0][WIDE_W-1:0] loc;
  logic [5:0]             valid_q;

  logic [PW-1:0]       ctr_ext, vec_ext;
  logic signed [W-1:0] ctr [3];
  logic signed [W-1:0] vec [3];

  // stage c
  logic [WIDE_W-1:0]   dc_d [3], dc_q [3];
  logic [WIDE_W-1:0]   pl_lo_d [3], pl_lo_q [3];
  logic [31:0]         pl_hi_d [3], pl_hi_q [3];
  logic signed [32+W:0] pl_lo_full [3];
  logic [WIDE_W-1:0]   nsq_d [3], nsq_q [3];
  logic [W-1:0]        rmag;
  logic [2*W-1:0]      rsq_d, rsq_q;

  // stage d
  logic [WIDE_W-1:0]   d_d [3], d_q [3];
  logic [WIDE_W-1:0]   pp_d [3], pp_q [3];
  logic [WIDE_W-1:0]   nn_d, nn_q;

  // stage e
  logic [2:0]          box_in_d, box_in_q;
  logic [WIDE_W-1:0]   ll_d [3], ll_q [3];
  logic [WIDE_W-1:0]   lh_d [3], lh_q [3];
  logic [WIDE_W-1:0]   hh_d [3], hh_q [3];
  logic [WIDE_W-1:0]   dot_d, dot_q;
  logic signed [32+W:0] sn_lo_full;
  logic [WIDE_W-1:0]   sn_lo_d, sn_lo_q;
  logic [31:0]         sn_hi_d, sn_hi_q;

  // stage f
  logic [SQ_W-1:0]     sq_d [3], sq_q [3];
  logic                box_inside_f_q;
  logic [WIDE_W-1:0]   f_d, f_q;

  // stage g
  logic [SQ_W-1:0]     sum_d, sum_q;
  logic                box_inside_g_q;
  logic                plane_rm_d, plane_rm_q;

  // stage h
  logic                sph_inside;
  logic                rm_d, rm_q;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_shape_q   <= SHAPE_NONE;
      use_full_q     <= 1'b1;
      kill_inside_q  <= 1'b0;
      shape_center_q <= '0;
      shape_vector_q <= '0;
      shape_scalar_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KILL_SHAPE:   kill_shape_q   <= kill_shape_e'(cfg_data_i[1:0]);
        CFG_USE_FULL_XFM: use_full_q     <= cfg_data_i[0];
        CFG_KILL_INSIDE:  kill_inside_q  <= cfg_data_i[0];
        CFG_SHAPE_CENTER: shape_center_q <= cfg_data_i;
        CFG_SHAPE_VECTOR: shape_vector_q <= cfg_data_i;
        CFG_SHAPE_SCALAR: shape_scalar_q <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // global stall when the output item is held
  assign en         = !(out_valid_o && !out_ready_i);
  assign in_ready_o = en;

  pkvt_xform #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_xform (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .en_i                (en),
    .valid_i             (in_valid_i),
    .use_full_i          (use_full_q),
    .pos_x_i             (pos_x_i),
    .pos_y_i             (pos_y_i),
    .pos_z_i             (pos_z_i),
    .inv_row0_i          (inv_row0_i),
    .inv_row1_i          (inv_row1_i),
    .inv_row2_i          (inv_row2_i),
    .inv_row3_i          (inv_row3_i),
    .global_translation_i(global_translation_i),
    .valid_o             (xf_valid),
    .loc_o               (loc)
  );

  // valid bits for stages c through h
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[4:0], xf_valid};
    end
  end

  // shape lane unpacking
  assign ctr_ext = PW'(shape_center_q[LANE_BITS-1:0]);
  assign vec_ext = PW'(shape_vector_q[LANE_BITS-1:0]);

  // stage c: offset from center, split plane products, normal and radius squares
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ctr[j]        = ctr_ext[j*W +: W];
      vec[j]        = vec_ext[j*W +: W];
      dc_d[j]       = loc[j] - (WIDE_W'(ctr[j]) << LOCAL_SHIFT);
      pl_lo_full[j] = $signed({1'b0, loc[j][31:0]}) * vec[j];
      pl_lo_d[j]    = WIDE_W'(pl_lo_full[j]);
      pl_hi_d[j]    = 32'(loc[j][63:32] * 32'(vec[j]));
      nsq_d[j]      = WIDE_W'(vec[j] * vec[j]);
    end
    rmag  = shape_scalar_q[W-1] ? W'(-shape_scalar_q) : W'(shape_scalar_q);
    rsq_d = (2*W)'(rmag) * (2*W)'(rmag);
  end

  // stage d: center distance magnitude, plane term per axis, sum of n squared
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_d[j]  = dc_q[j][WIDE_W-1] ? (WIDE_W'(0) - dc_q[j]) : dc_q[j];
      pp_d[j] = pl_lo_q[j] + {pl_hi_q[j], 32'b0};
    end
    nn_d = nsq_q[0] + nsq_q[1] + nsq_q[2];
  end

  // stage e: box compare, split squares, plane dot, offset times n squared
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      box_in_d[j] = !vec[j][W-1] && (d_q[j] <= (WIDE_W'(vec[j]) << LOCAL_SHIFT));
      ll_d[j]     = d_q[j][31:0] * d_q[j][31:0];
      lh_d[j]     = d_q[j][31:0] * d_q[j][63:32];
      hh_d[j]     = d_q[j][63:32] * d_q[j][63:32];
    end
    dot_d      = pp_q[0] + pp_q[1] + pp_q[2];
    sn_lo_full = $signed({1'b0, nn_q[31:0]}) * shape_scalar_q;
    sn_lo_d    = WIDE_W'(sn_lo_full);
    sn_hi_d    = 32'(nn_q[63:32] * 32'(shape_scalar_q));
  end

  // stage f: exact squares, plane distance
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_d[j] = (SQ_W'(hh_q[j]) << 64) + (SQ_W'(lh_q[j]) << 33) + SQ_W'(ll_q[j]);
    end
    f_d = dot_q - (sn_lo_q + {sn_hi_q, 32'b0});
  end

  // stage g: squared distance total, plane sign
  always_comb begin
    sum_d      = sq_q[0] + sq_q[1] + sq_q[2];
    plane_rm_d = !f_q[WIDE_W-1] && (f_q != '0);
  end

  // stage h: sphere compare and final decision
  always_comb begin
    sph_inside = sum_q <= (SQ_W'(rsq_q) << 32);
    case (kill_shape_q)
      SHAPE_NONE:   rm_d = 1'b0;
      SHAPE_BOX:    rm_d = (box_inside_g_q == kill_inside_q);
      SHAPE_PLANE:  rm_d = plane_rm_q;
      SHAPE_SPHERE: rm_d = (sph_inside == kill_inside_q);
      default:      rm_d = 1'b0;
    endcase
  end

  // values that follow only the configuration
  always_ff @(posedge clk_i) begin
    nsq_q <= nsq_d;
    rsq_q <= rsq_d;
    nn_q  <= nn_d;
  end

  // pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      dc_q           <= dc_d;
      pl_lo_q        <= pl_lo_d;
      pl_hi_q        <= pl_hi_d;
      d_q            <= d_d;
      pp_q           <= pp_d;
      box_in_q       <= box_in_d;
      ll_q           <= ll_d;
      lh_q           <= lh_d;
      hh_q           <= hh_d;
      dot_q          <= dot_d;
      sn_lo_q        <= sn_lo_d;
      sn_hi_q        <= sn_hi_d;
      sq_q           <= sq_d;
      box_inside_f_q <= &box_in_q;
      f_q            <= f_d;
      sum_q          <= sum_d;
      box_inside_g_q <= box_inside_f_q;
      plane_rm_q     <= plane_rm_d;
      rm_q           <= rm_d;
    end
  end

  assign out_valid_o       = valid_q[5];
  assign remove_particle_o = rm_q;

endmodule

`default_nettype wire
